/* rtl/free_extent_table_allocator_unit_assert.svh */
// Assertion macros for the free extent table allocator.
// Included by the top level; no other dependencies.
`ifndef FREE_EXTENT_TABLE_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_EXTENT_TABLE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every edge outside reset
`define FETA_ASSERT_HOLDS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("feta assertion failed");
// antecedent implies consequent in the same cycle
`define FETA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("feta assertion failed");
// antecedent implies consequent in the next cycle
`define FETA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("feta assertion failed");
`else
`define FETA_ASSERT_HOLDS(lbl, clk, rstn, prop)
`define FETA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FETA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/feta_pkg.sv */
// Types and codes shared by the free extent table allocator.
// No dependencies.
package feta_pkg;

	localparam int START_W     = 16;
	localparam int LENGTH_W    = 17;
	localparam int CFG_W       = 17;
	localparam int COUNT_OUT_W = 7;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_RANGE   = 2'd1,
		STATUS_OVERLAP = 2'd2,
		STATUS_FULL    = 2'd3
	} feta_status_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_PLACE,
		ST_DONE
	} feta_state_t;

	typedef struct packed {
		logic                mode;
		logic [START_W-1:0]  start_req;
		logic [LENGTH_W-1:0] length;
	} feta_req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [COUNT_OUT_W-1:0] free_extent_count;
	} feta_rsp_t;

endpackage

/* rtl/feta_entry_ram.sv */
// Extent table storage: one write port, one read port, registered read data.
// No dependencies.
module feta_entry_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/free_extent_table_allocator_unit.sv */
// Free extent table allocator, top level.
// Depends on feta_pkg, feta_entry_ram and the assertion macro header.

// Keeps up to MAX_EXTENTS free extents, sorted by start, in one single-port-read RAM
// and answers each request with a status and the extent count. A request is taken in
// idle; a zero-length one goes straight to the result. Otherwise the table is walked one
// entry per cycle until the scan stops, the request is decided, entries are moved one per
// cycle when an extent is inserted or removed, a new extent is placed if one is inserted,
// and the result is handed over, waiting on out_ready while the output register is full.
// Entries scanned and entries moved together never pass the extent count. The next
// request is taken only in idle, once this result is loaded. A request is not taken
// while a total_length write is offered. After reset and after each write of total_length
// the table is rebuilt in the init state before a request is taken.
module free_extent_table_allocator_unit #(
	parameter int MAX_EXTENTS  = 64,
	parameter int ADDRESS_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [feta_pkg::CFG_W-1:0]  total_length,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  feta_pkg::feta_req_t         in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output feta_pkg::feta_rsp_t         out_data
);

	import feta_pkg::*;

`include "free_extent_table_allocator_unit_assert.svh"

	localparam int IW      = $clog2(MAX_EXTENTS);
	localparam int CW      = $clog2(MAX_EXTENTS + 1);
	localparam int SW      = ADDRESS_BITS;
	localparam int ZW      = ADDRESS_BITS + 1;
	localparam int EW      = (ADDRESS_BITS + 1 > LENGTH_W + 1) ? ADDRESS_BITS + 1 : LENGTH_W + 1;
	localparam int ENTRY_W = SW + ZW;

	localparam logic [EW-1:0] SPACE_CAP   = {{(EW-1){1'b0}}, 1'b1} << ADDRESS_BITS;
	localparam logic [EW-1:0] CFG_RESET   = EW'(65536);
	localparam logic [ZW-1:0] SPACE_RESET =
		ZW'((CFG_RESET > SPACE_CAP) ? SPACE_CAP : CFG_RESET);
	localparam logic [CW-1:0] MAX_C       = CW'(MAX_EXTENTS);

	// control state
	feta_state_t       state_q, state_d;
	logic [ZW-1:0]     space_q;
	logic [CW-1:0]     count_q;
	logic              out_valid_q;

	// request and scan registers
	logic              mode_q;
	logic [EW-1:0]     s_q, len_q, e_q;
	logic [CW-1:0]     k_q;
	logic              has_prev_q, has_cur_q;
	logic [SW-1:0]     prev_st_q, cur_st_q;
	logic [ZW-1:0]     prev_sz_q, cur_sz_q;
	logic [EW-1:0]     prev_end_q;
	logic [1:0]        status_q;
	feta_rsp_t         out_data_q;

	// shift and placement registers
	logic [IW-1:0]     sh_q, sh_last_q;
	logic              sh_up_q;
	logic              place_pend_q;
	logic [IW-1:0]     place_addr_q;
	logic [ENTRY_W-1:0] place_data_q;

	// RAM port signals
	logic [IW-1:0]      rd_addr, wr_addr;
	logic [ENTRY_W-1:0] rd_data, wr_data;
	logic               wr_en;

	feta_entry_ram #(
		.DEPTH(MAX_EXTENTS),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk    (clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// handshakes
	logic cfg_fire, in_fire, out_load;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// saturated space size from the register write
	logic [EW-1:0] tl_e, tl_sat;
	assign tl_e   = EW'(total_length);
	assign tl_sat = (tl_e > SPACE_CAP) ? SPACE_CAP : tl_e;

	// index helpers
	logic [CW-1:0] k_inc, k_dec, cnt_dec;
	logic [IW-1:0] kk, pk, kp1, cnt_m1;
	assign k_inc  = k_q + CW'(1);
	assign k_dec  = k_q - CW'(1);
	assign cnt_dec = count_q - CW'(1);
	assign kk     = k_q[IW-1:0];
	assign pk     = k_dec[IW-1:0];
	assign kp1    = k_inc[IW-1:0];
	assign cnt_m1 = cnt_dec[IW-1:0];

	// entry arriving from the RAM
	logic [SW-1:0] rd_st;
	logic [ZW-1:0] rd_sz;
	logic          at_end, stop_hit, scan_stop;
	assign rd_st     = rd_data[ENTRY_W-1 -: SW];
	assign rd_sz     = rd_data[ZW-1:0];
	assign at_end    = (k_q == count_q);
	assign stop_hit  = (mode_q == MODE_FREE) ? (EW'(rd_st) >= s_q) : (EW'(rd_st) > s_q);
	assign scan_stop = at_end || stop_hit;

	// decision terms
	logic [EW-1:0] prev_sz_e, cur_sz_e, cur_st_e, prev_st_e;
	logic          full, a_miss, a_front, a_back;
	logic          f_range, f_over, adj_b, adj_c;
	assign prev_sz_e = EW'(prev_sz_q);
	assign cur_sz_e  = EW'(cur_sz_q);
	assign cur_st_e  = EW'(cur_st_q);
	assign prev_st_e = EW'(prev_st_q);
	assign full      = (count_q >= MAX_C);
	assign a_miss    = !has_prev_q || (s_q >= prev_end_q) || (e_q > prev_end_q);
	assign a_front   = (s_q == prev_st_e);
	assign a_back    = (e_q == prev_end_q);
	assign f_range   = (e_q > EW'(space_q));
	assign f_over    = (has_prev_q && (prev_end_q > s_q)) || (has_cur_q && (cur_st_e < e_q));
	assign adj_b     = has_prev_q && (prev_end_q == s_q);
	assign adj_c     = has_cur_q && (cur_st_e == e_q);

	// sums that become new sizes
	logic [EW-1:0] sz_shrink, sz_grow_b, sz_merge, sz_grow_c, sz_head, sz_tail;
	assign sz_shrink = prev_sz_e - len_q;
	assign sz_grow_b = prev_sz_e + len_q;
	assign sz_merge  = sz_grow_b + cur_sz_e;
	assign sz_grow_c = cur_sz_e + len_q;
	assign sz_head   = s_q - prev_st_e;
	assign sz_tail   = prev_end_q - e_q;

	// decision outcome
	logic [1:0]         dec_status;
	logic               dec_wr, dec_shift, dec_up, dec_place, dec_inc, dec_dec;
	logic [IW-1:0]      dec_wr_addr, dec_src0, dec_last, dec_place_addr;
	logic [ENTRY_W-1:0] dec_wr_data, dec_place_data;

	always_comb begin
		dec_status     = STATUS_OK;
		dec_wr         = 1'b0;
		dec_wr_addr    = pk;
		dec_wr_data    = {prev_st_q, sz_shrink[ZW-1:0]};
		dec_shift      = 1'b0;
		dec_up         = 1'b0;
		dec_src0       = kk;
		dec_last       = cnt_m1;
		dec_place      = 1'b0;
		dec_place_addr = kk;
		dec_place_data = {s_q[SW-1:0], len_q[ZW-1:0]};
		dec_inc        = 1'b0;
		dec_dec        = 1'b0;
		if (mode_q == MODE_FREE) begin
			priority if (f_range) begin
				dec_status = STATUS_RANGE;
			end else if (f_over) begin
				dec_status = STATUS_OVERLAP;
			end else if (adj_b && adj_c) begin
				// bridge two extents, drop the later one
				dec_wr      = 1'b1;
				dec_wr_data = {prev_st_q, sz_merge[ZW-1:0]};
				dec_shift   = (k_inc < count_q);
				dec_src0    = kp1;
				dec_dec     = 1'b1;
			end else if (adj_b) begin
				dec_wr      = 1'b1;
				dec_wr_data = {prev_st_q, sz_grow_b[ZW-1:0]};
			end else if (adj_c) begin
				dec_wr      = 1'b1;
				dec_wr_addr = kk;
				dec_wr_data = {s_q[SW-1:0], sz_grow_c[ZW-1:0]};
			end else if (full) begin
				dec_status = STATUS_FULL;
			end else begin
				// new extent at the scan position
				dec_shift = has_cur_q;
				dec_up    = 1'b1;
				dec_src0  = cnt_m1;
				dec_last  = kk;
				dec_place = 1'b1;
				dec_inc   = 1'b1;
			end
		end else begin
			priority if (a_miss) begin
				dec_status = STATUS_RANGE;
			end else if (a_front && a_back) begin
				// exact fit, remove the extent
				dec_shift = has_cur_q;
				dec_src0  = kk;
				dec_dec   = 1'b1;
			end else if (a_front) begin
				dec_wr      = 1'b1;
				dec_wr_data = {e_q[SW-1:0], sz_shrink[ZW-1:0]};
			end else if (a_back) begin
				dec_wr = 1'b1;
			end else if (full) begin
				dec_status = STATUS_FULL;
			end else begin
				// split: keep the head, insert the tail after it
				dec_wr         = 1'b1;
				dec_wr_data    = {prev_st_q, sz_head[ZW-1:0]};
				dec_shift      = has_cur_q;
				dec_up         = 1'b1;
				dec_src0       = cnt_m1;
				dec_last       = kk;
				dec_place      = 1'b1;
				dec_place_data = {e_q[SW-1:0], sz_tail[ZW-1:0]};
				dec_inc        = 1'b1;
			end
		end
	end

	// shift addressing
	logic [IW-1:0] sh_next, sh_dst;
	logic          sh_done;
	assign sh_next = sh_up_q ? (sh_q - IW'(1)) : (sh_q + IW'(1));
	assign sh_dst  = sh_up_q ? (sh_q + IW'(1)) : (sh_q - IW'(1));
	assign sh_done = (sh_q == sh_last_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:   state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (in_data.length == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_stop) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (dec_status != STATUS_OK) begin
					state_d = ST_DONE;
				end else if (dec_shift) begin
					state_d = ST_SHIFT;
				end else if (dec_place) begin
					state_d = ST_PLACE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (sh_done) begin
					state_d = place_pend_q ? ST_PLACE : ST_DONE;
				end
			end
			ST_PLACE:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_INIT;
		endcase
		if (cfg_fire) begin
			state_d = ST_INIT;
		end
	end

	// RAM port drive per state
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {{SW{1'b0}}, space_q};
		unique case (state_q)
			ST_INIT: begin
				wr_en = (space_q != '0);
			end
			ST_SCAN: begin
				rd_addr = kp1;
			end
			ST_DECIDE: begin
				rd_addr = dec_src0;
				wr_en   = dec_wr && (dec_status == STATUS_OK);
				wr_addr = dec_wr_addr;
				wr_data = dec_wr_data;
			end
			ST_SHIFT: begin
				rd_addr = sh_next;
				wr_en   = 1'b1;
				wr_addr = sh_dst;
				wr_data = rd_data;
			end
			ST_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = place_addr_q;
				wr_data = place_data_q;
			end
			ST_IDLE, ST_DONE: begin
				rd_addr = '0;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			space_q     <= SPACE_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				space_q <= tl_sat[ZW-1:0];
			end
			if (state_q == ST_INIT) begin
				count_q <= (space_q != '0) ? CW'(1) : CW'(0);
			end else if (state_q == ST_DECIDE && dec_status == STATUS_OK) begin
				if (dec_inc) begin
					count_q <= count_q + CW'(1);
				end else if (dec_dec) begin
					count_q <= cnt_dec;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and scan bookkeeping
	logic [31:0] cnt_wide;
	assign cnt_wide = 32'(count_q);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q     <= in_data.mode;
			s_q        <= EW'(in_data.start_req);
			len_q      <= EW'(in_data.length);
			e_q        <= EW'(in_data.start_req) + EW'(in_data.length);
			k_q        <= '0;
			has_prev_q <= 1'b0;
			status_q   <= STATUS_OK;
		end
		if (state_q == ST_SCAN) begin
			if (scan_stop) begin
				has_cur_q <= !at_end;
				cur_st_q  <= rd_st;
				cur_sz_q  <= rd_sz;
			end else begin
				has_prev_q <= 1'b1;
				prev_st_q  <= rd_st;
				prev_sz_q  <= rd_sz;
				prev_end_q <= EW'(rd_st) + EW'(rd_sz);
				k_q        <= k_inc;
			end
		end
		if (state_q == ST_DECIDE) begin
			status_q       <= dec_status;
			sh_q           <= dec_src0;
			sh_last_q      <= dec_last;
			sh_up_q        <= dec_up;
			place_pend_q   <= dec_place;
			place_addr_q   <= dec_place_addr;
			place_data_q   <= dec_place_data;
		end
		if (state_q == ST_SHIFT && !sh_done) begin
			sh_q <= sh_next;
		end
		if (out_load) begin
			out_data_q.status            <= status_q;
			out_data_q.free_extent_count <= cnt_wide[COUNT_OUT_W-1:0];
		end
	end

	// checks
	`FETA_ASSERT_HOLDS(a_count_bound, clk, arst_n, count_q <= MAX_C)
	`FETA_ASSERT_IMPL(a_scan_index, clk, arst_n, state_q == ST_SCAN, k_q <= count_q)
	`FETA_ASSERT_IMPL(a_shift_no_clash, clk, arst_n, state_q == ST_SHIFT && !sh_done, wr_addr != rd_addr)
	`FETA_ASSERT_NEXT(a_scan_count_stable, clk, arst_n, state_q == ST_SCAN, $stable(count_q))

endmodule

/* tb/tb_free_extent_table_allocator_unit.sv */
// Testbench for the free extent table allocator: random and directed allocate/free requests
// checked against a behavioral extent table. Depends on feta_pkg and the allocator top level.
`timescale 1ns / 1ps

module tb_free_extent_table_allocator_unit;
	import feta_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int SPACE_CAP   = 65536;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] total_length = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	feta_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	feta_rsp_t out_data;

	free_extent_table_allocator_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .total_length(total_length),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #6 clk = ~clk;

	// model of the extent table
	int unsigned ext_base[TABLE_DEPTH];
	int unsigned ext_len[TABLE_DEPTH];
	int unsigned ext_num;
	int unsigned space_len;

	feta_req_t pending_reqs[$];
	feta_rsp_t expected_rsps[$];
	int unsigned fail_count = 0;
	int unsigned rsp_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic hold_off = 1'b0;
	longint cycle_count = 0;
	int unsigned ok_seen = 0, err_seen = 0;

	function automatic void table_reinit(input int unsigned tl);
		space_len = (tl > SPACE_CAP) ? SPACE_CAP : tl;
		ext_num = (space_len == 0) ? 0 : 1;
		ext_base[0] = 0;
		ext_len[0] = space_len;
	endfunction

	function automatic void drop_at(input int unsigned i);
		for (int unsigned k = i; k + 1 < ext_num; k++) begin
			ext_base[k] = ext_base[k + 1];
			ext_len[k] = ext_len[k + 1];
		end
		ext_num--;
	endfunction

	function automatic void insert_at(input int unsigned i, input int unsigned b,
			input int unsigned l);
		for (int k = int'(ext_num); k > int'(i); k--) begin
			ext_base[k] = ext_base[k - 1];
			ext_len[k] = ext_len[k - 1];
		end
		ext_base[i] = b;
		ext_len[i] = l;
		ext_num++;
	endfunction

	function automatic feta_status_t take_range(input int unsigned s, input int unsigned n);
		int unsigned i;
		int unsigned e, es, ee;
		e = s + n;
		for (i = 0; i < ext_num; i++)
			if (s >= ext_base[i] && s < ext_base[i] + ext_len[i])
				break;
		if (i == ext_num)
			return STATUS_RANGE;
		es = ext_base[i];
		ee = es + ext_len[i];
		if (e > ee)
			return STATUS_RANGE;
		if (s == es && e == ee) begin
			drop_at(i);
		end else if (s == es) begin
			ext_base[i] = e;
			ext_len[i] -= n;
		end else if (e == ee) begin
			ext_len[i] -= n;
		end else begin
			if (ext_num >= TABLE_DEPTH)
				return STATUS_FULL;
			ext_len[i] = s - es;
			insert_at(i + 1, e, ee - e);
		end
		return STATUS_OK;
	endfunction

	function automatic feta_status_t give_back(input int unsigned s, input int unsigned n);
		int unsigned c;
		int unsigned e;
		bit hb, hc, ab, ac;
		c = 0;
		e = s + n;
		if (e > space_len)
			return STATUS_RANGE;
		while (c < ext_num && s > ext_base[c])
			c++;
		hb = c > 0;
		hc = c < ext_num;
		if (hb && ext_base[c - 1] + ext_len[c - 1] > s)
			return STATUS_OVERLAP;
		if (hc && ext_base[c] < e)
			return STATUS_OVERLAP;
		ab = hb && (ext_base[c - 1] + ext_len[c - 1] == s);
		ac = hc && (ext_base[c] == e);
		if (ab && ac) begin
			ext_len[c - 1] += n + ext_len[c];
			drop_at(c);
		end else if (ab) begin
			ext_len[c - 1] += n;
		end else if (ac) begin
			ext_base[c] = s;
			ext_len[c] += n;
		end else begin
			if (ext_num >= TABLE_DEPTH)
				return STATUS_FULL;
			insert_at(c, s, n);
		end
		return STATUS_OK;
	endfunction

	function automatic feta_rsp_t predict_rsp(input feta_req_t r);
		feta_rsp_t p;
		feta_status_t st;
		st = STATUS_OK;
		if (r.length != 0)
			st = (r.mode == MODE_FREE) ? give_back(r.start_req, r.length)
				: take_range(r.start_req, r.length);
		p.status = st;
		p.free_extent_count = ext_num[COUNT_OUT_W-1:0];
		return p;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_rsps.push_back(predict_rsp(in_data));
				void'(pending_reqs.pop_front());
			end
			if (in_valid && !in_ready) begin
				// hold payload until accepted
			end else if (pending_reqs.size() > (in_valid && in_ready ? 0 : 0) && !hold_off
					&& $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_reqs[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// response monitor and stall generator
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				rsp_count++;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %p", $time, out_data);
					fail_count++;
				end else begin
					feta_rsp_t x;
					x = expected_rsps.pop_front();
					if (x.status != out_data.status) begin
						$display("%0t: status mismatch expected %0d actual %0d", $time,
							x.status, out_data.status);
						fail_count++;
					end
					if (x.free_extent_count != out_data.free_extent_count) begin
						$display("%0t: extent count mismatch expected %0d actual %0d",
							$time, x.free_extent_count, out_data.free_extent_count);
						fail_count++;
					end
					if (x.status == STATUS_OK)
						ok_seen++;
					else
						err_seen++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic feta_req_t mk_req(input logic m, input int unsigned s,
			input int unsigned n);
		feta_req_t r;
		r.mode = m;
		r.start_req = s[START_W-1:0];
		r.length = n[LENGTH_W-1:0];
		return r;
	endfunction

	// random request with a bias toward valid operations on the current space
	function automatic feta_req_t rand_req(input int unsigned sp);
		int unsigned s, n, lim;
		lim = (sp == 0) ? 1 : sp;
		if ($urandom_range(9) == 0) begin
			return mk_req(1'($urandom_range(1)), $urandom_range(65535),
				$urandom_range(131071));
		end
		s = $urandom_range(lim - 1);
		if ($urandom_range(3) == 0)
			n = $urandom_range(lim - s);
		else
			n = $urandom_range((lim - s < 8) ? lim - s : 8);
		if (n == 0 && $urandom_range(7) != 0)
			n = 1;
		return mk_req(1'($urandom_range(1)), s, n);
	endfunction

	task automatic wait_drain();
		while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_total(input int unsigned tl);
		cfg_valid <= 1'b1;
		total_length <= tl[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		table_reinit(tl & 32'h1FFFF);
		@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned tl, input int unsigned nreq,
			input int unsigned idle_pct, input int unsigned stall_pct);
		write_total(tl);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int unsigned k = 0; k < nreq; k++)
			pending_reqs.push_back(rand_req((tl > SPACE_CAP) ? SPACE_CAP : tl));
		wait_drain();
	endtask

	initial begin
		table_reinit(SPACE_CAP);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, splits, merges, error codes, zero length
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0, 0));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 100, 10));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0, 5));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 65530, 6));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 200, 131071));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 100, 1));
		pending_reqs.push_back(mk_req(MODE_FREE, 300, 4));
		pending_reqs.push_back(mk_req(MODE_FREE, 102, 3));
		pending_reqs.push_back(mk_req(MODE_FREE, 100, 2));
		pending_reqs.push_back(mk_req(MODE_FREE, 105, 5));
		pending_reqs.push_back(mk_req(MODE_FREE, 65535, 2));
		pending_reqs.push_back(mk_req(MODE_FREE, 0, 5));
		pending_reqs.push_back(mk_req(MODE_FREE, 65530, 6));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0, 65536));
		pending_reqs.push_back(mk_req(MODE_FREE, 65535, 1));
		pending_reqs.push_back(mk_req(MODE_FREE, 0, 65535));
		pending_reqs.push_back(mk_req(MODE_FREE, 0, 0));
		wait_drain();

		// fill the table with splits until full, then free beyond it
		write_total(300);
		for (int unsigned k = 0; k < 66; k++)
			pending_reqs.push_back(mk_req(MODE_ALLOC, 2 + 4 * k, 1));
		wait_drain();
		for (int unsigned k = 0; k < 8; k++)
			pending_reqs.push_back(mk_req(MODE_FREE, 2 + 4 * k, 1));
		pending_reqs.push_back(mk_req(MODE_FREE, 299, 2));
		wait_drain();

		// hold the sender off with one request queued, then release it and drain
		hold_off = 1'b1;
		pending_reqs.push_back(mk_req(MODE_ALLOC, 10, 3));
		repeat (50) @(posedge clk);
		hold_off = 1'b0;
		wait_drain();

		write_total(0);
		pending_reqs.push_back(mk_req(MODE_FREE, 0, 1));
		pending_reqs.push_back(mk_req(MODE_ALLOC, 0, 1));
		wait_drain();

		run_phase(1, 40, 0, 0);
		run_phase(131071, 60, 0, 0);
		run_phase(200, 100, 0, 0);
		run_phase(96, 200, 78, 0);
		run_phase(160, 200, 0, 78);
		run_phase(65536, 120, 7, 7);
		run_phase(40, 200, 7, 7);
		run_phase(65535, 40, 0, 0);

		$display("Covered %0d responses: %0d ok, %0d error statuses, spaces from 0 to 2^17-1.",
			rsp_count, ok_seen, err_seen);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/feta_pkg.sv
rtl/feta_entry_ram.sv
rtl/free_extent_table_allocator_unit.sv
tb/tb_free_extent_table_allocator_unit.sv
